// File: rtl/ibpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ibpa_pkg;

    // fixed-point constants
    localparam int unsigned ONE_Q16          = 65536;
    localparam logic [31:0] SCALE_RESET      = 32'h0100_0000;
    localparam logic [14:0] DET_WIDTH_RESET  = 15'd1024;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_SCALE     = 1'b0,
        REG_DET_WIDTH = 1'b1
    } cfg_reg_t;

    // one projection term of a voxel update
    typedef struct packed {
        logic signed [15:0] x_index;
        logic        [16:0] weight;
        logic signed [15:0] cos_angle;
        logic signed [31:0] sample_left;
        logic signed [31:0] sample_right;
        logic signed [31:0] voxel_in;
        logic               last_term;
    } in_item_t;

    // updated voxel
    typedef struct packed {
        logic signed [31:0] voxel_out;
        logic               saturated;
    } out_item_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_MUL_F,
        ST_INTERP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_COMBINE,
        ST_ROUND,
        ST_ACCUM,
        ST_FINAL
    } state_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_L,
        OP_MUL_R,
        OP_MUL_F,
        OP_INTERP,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_COMBINE,
        OP_ROUND,
        OP_ACCUM,
        OP_FINAL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic last_term;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/ibpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ibpa_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    output ibpa_pkg::dp_cmd_t    cmd,
    input  ibpa_pkg::dp_status_t status
);

    ibpa_pkg::state_t state_reg;
    ibpa_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // state and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ibpa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sequencing of the shared multiplier and the accumulator
    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = ibpa_pkg::OP_NONE;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            ibpa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = ibpa_pkg::OP_LOAD;
                    state_next = ibpa_pkg::ST_MUL_L;
                end
            end
            ibpa_pkg::ST_MUL_L:
            begin
                cmd.op     = ibpa_pkg::OP_MUL_L;
                state_next = ibpa_pkg::ST_MUL_R;
            end
            ibpa_pkg::ST_MUL_R:
            begin
                cmd.op     = ibpa_pkg::OP_MUL_R;
                state_next = ibpa_pkg::ST_MUL_F;
            end
            ibpa_pkg::ST_MUL_F:
            begin
                cmd.op     = ibpa_pkg::OP_MUL_F;
                state_next = ibpa_pkg::ST_INTERP;
            end
            ibpa_pkg::ST_INTERP:
            begin
                cmd.op     = ibpa_pkg::OP_INTERP;
                state_next = ibpa_pkg::ST_MUL_LO;
            end
            ibpa_pkg::ST_MUL_LO:
            begin
                cmd.op     = ibpa_pkg::OP_MUL_LO;
                state_next = ibpa_pkg::ST_MUL_HI;
            end
            ibpa_pkg::ST_MUL_HI:
            begin
                cmd.op     = ibpa_pkg::OP_MUL_HI;
                state_next = ibpa_pkg::ST_COMBINE;
            end
            ibpa_pkg::ST_COMBINE:
            begin
                cmd.op     = ibpa_pkg::OP_COMBINE;
                state_next = ibpa_pkg::ST_ROUND;
            end
            ibpa_pkg::ST_ROUND:
            begin
                cmd.op     = ibpa_pkg::OP_ROUND;
                state_next = ibpa_pkg::ST_ACCUM;
            end
            ibpa_pkg::ST_ACCUM:
            begin
                cmd.op     = ibpa_pkg::OP_ACCUM;
                state_next = status.last_term ? ibpa_pkg::ST_FINAL : ibpa_pkg::ST_IDLE;
            end
            ibpa_pkg::ST_FINAL:
            begin
                // wait for a free output slot
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = ibpa_pkg::OP_FINAL;
                    out_valid_next = 1'b1;
                    state_next     = ibpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ibpa_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/ibpa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ibpa_datapath (
    input  wire                   clk,
    input  wire                   rst_n,
    input  ibpa_pkg::dp_cmd_t     cmd,
    output ibpa_pkg::dp_status_t  status,
    input  ibpa_pkg::in_item_t    in_data,
    output ibpa_pkg::out_item_t   out_data,
    input  wire                   cfg_write,
    input  ibpa_pkg::cfg_reg_t    cfg_index,
    input  wire [31:0]            cfg_data
);

    // configuration and running sum
    logic        [31:0] scale_reg;
    logic        [14:0] det_width_reg;
    logic signed [63:0] sum_reg;
    logic signed [63:0] sum_next;

    // latched term
    logic signed [31:0] left_reg;
    logic signed [31:0] right_reg;
    logic        [16:0] w_reg;
    logic        [16:0] wc_reg;
    logic signed [15:0] cos_reg;
    logic signed [31:0] vox_reg;
    logic               last_reg;

    // working registers
    logic signed [52:0] prod_reg;
    logic signed [49:0] acc_reg;
    logic signed [33:0] f_reg;
    logic signed [31:0] interp_reg;
    logic signed [52:0] lo_reg;
    logic signed [63:0] full_reg;
    logic signed [39:0] term_reg;
    ibpa_pkg::out_item_t out_reg;

    // load-time values
    logic        [16:0] w_clamped;
    logic signed [16:0] x_plus_one;
    logic               left_ok;
    logic               right_ok;

    // shared multiplier
    logic signed [34:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [52:0] mul_p;

    // rounding, clamping and saturation
    logic signed [52:0] f_rounded;
    logic signed [49:0] acc_rounded;
    logic signed [33:0] interp_wide;
    logic signed [31:0] interp_clamped;
    logic signed [63:0] full_next;
    logic signed [63:0] full_rounded;
    logic signed [64:0] sum_wide;
    logic signed [64:0] total_wide;
    ibpa_pkg::out_item_t final_item;

    // weight clamp and bin validity
    always_comb
    begin
        w_clamped  = (in_data.weight > 17'(ibpa_pkg::ONE_Q16))
                   ? 17'(ibpa_pkg::ONE_Q16) : in_data.weight;
        x_plus_one = 17'(in_data.x_index) + 17'sd1;
        left_ok    = !in_data.x_index[15]
                   && (in_data.x_index[14:0] < det_width_reg);
        right_ok   = !x_plus_one[16]
                   && (x_plus_one[15:0] < {1'b0, det_width_reg});
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            ibpa_pkg::OP_MUL_L:
            begin
                mul_a = 35'(left_reg);
                mul_b = {1'b0, w_reg};
            end
            ibpa_pkg::OP_MUL_R:
            begin
                mul_a = 35'(right_reg);
                mul_b = {1'b0, wc_reg};
            end
            ibpa_pkg::OP_MUL_F:
            begin
                mul_a = {3'b000, scale_reg};
                mul_b = 18'(cos_reg);
            end
            ibpa_pkg::OP_MUL_LO:
            begin
                mul_a = 35'(f_reg);
                mul_b = {2'b00, interp_reg[15:0]};
            end
            ibpa_pkg::OP_MUL_HI:
            begin
                mul_a = 35'(f_reg);
                mul_b = 18'($signed(interp_reg[31:16]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // round half up and clamp steps
    always_comb
    begin
        f_rounded      = prod_reg + 53'sd16384;
        acc_rounded    = acc_reg + 50'sd32768;
        interp_wide    = acc_rounded[49:16];
        if (interp_wide > 34'sh0_7FFF_FFFF)
            interp_clamped = 32'sh7FFF_FFFF;
        else if (interp_wide < -34'sh0_8000_0000)
            interp_clamped = -32'sh8000_0000;
        else
            interp_clamped = interp_wide[31:0];

        full_next    = 64'(lo_reg) + {prod_reg[47:0], 16'h0000};
        full_rounded = full_reg + 64'sd8388608;

        // saturating accumulate
        sum_wide = 65'(sum_reg) + 65'(term_reg);
        if (sum_wide[64] != sum_wide[63])
            sum_next = sum_wide[64] ? {1'b1, 63'h0} : {1'b0, {63{1'b1}}};
        else
            sum_next = sum_wide[63:0];

        // final voxel with 32-bit clip
        total_wide = 65'(vox_reg) + 65'(sum_reg);
        if (total_wide[64:31] != {34{total_wide[64]}})
        begin
            final_item.voxel_out = total_wide[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            final_item.saturated = 1'b1;
        end
        else
        begin
            final_item.voxel_out = total_wide[31:0];
            final_item.saturated = 1'b0;
        end
    end

    // configuration registers and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= ibpa_pkg::SCALE_RESET;
            det_width_reg <= ibpa_pkg::DET_WIDTH_RESET;
            sum_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    ibpa_pkg::REG_SCALE:     scale_reg     <= cfg_data;
                    ibpa_pkg::REG_DET_WIDTH: det_width_reg <= cfg_data[14:0];
                    default:                 scale_reg     <= scale_reg;
                endcase
            end
            if (cmd.op == ibpa_pkg::OP_ACCUM)
                sum_reg <= sum_next;
            else if (cmd.op == ibpa_pkg::OP_FINAL)
                sum_reg <= '0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ibpa_pkg::OP_LOAD:
            begin
                left_reg  <= left_ok ? in_data.sample_left : 32'sd0;
                right_reg <= right_ok ? in_data.sample_right : 32'sd0;
                w_reg     <= w_clamped;
                wc_reg    <= 17'(ibpa_pkg::ONE_Q16) - w_clamped;
                cos_reg   <= in_data.cos_angle;
                vox_reg   <= in_data.voxel_in;
                last_reg  <= in_data.last_term;
            end
            ibpa_pkg::OP_MUL_L:
            begin
                prod_reg <= mul_p;
            end
            ibpa_pkg::OP_MUL_R:
            begin
                prod_reg <= mul_p;
                acc_reg  <= prod_reg[49:0];
            end
            ibpa_pkg::OP_MUL_F:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + prod_reg[49:0];
            end
            ibpa_pkg::OP_INTERP:
            begin
                f_reg      <= f_rounded[48:15];
                interp_reg <= interp_clamped;
            end
            ibpa_pkg::OP_MUL_LO:
            begin
                prod_reg <= mul_p;
            end
            ibpa_pkg::OP_MUL_HI:
            begin
                prod_reg <= mul_p;
                lo_reg   <= prod_reg;
            end
            ibpa_pkg::OP_COMBINE:
            begin
                full_reg <= full_next;
            end
            ibpa_pkg::OP_ROUND:
            begin
                term_reg <= full_rounded[63:24];
            end
            ibpa_pkg::OP_FINAL:
            begin
                out_reg <= final_item;
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

    assign status.last_term = last_reg;
    assign out_data         = out_reg;

endmodule

`default_nettype wire

// File: rtl/interpolated_backprojection_accumulate_top.sv
// path: a term runs through the multiply, interpolate, combine, round and accumulate
//   states, one term at a time, on a single shared 35x18 multiplier used five times
//   per term; a last term's result is registered in the final state
// a finished voxel waits in the output register while the next term is taken
// reset: scale 1.0, detector width 1024, running sum cleared, no result pending
`timescale 1ns / 1ps
`default_nettype none

module interpolated_backprojection_accumulate_top (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  ibpa_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output ibpa_pkg::out_item_t  out_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  ibpa_pkg::cfg_reg_t   cfg_index,
    input  wire [31:0]           cfg_data
);

    ibpa_pkg::dp_cmd_t    cmd;
    ibpa_pkg::dp_status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // controller
    ibpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath
    ibpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

`default_nettype wire
